/* rtl/bounded_sorted_top_k_insert_unit_macros.svh */
// ----------------------------------------------------------------------------
// bounded_sorted_top_k_insert_unit_macros.svh
// Assertion macros for the checker file. Each expects clk and rst in
// the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_TOP_K_INSERT_UNIT_MACROS_SVH
`define BOUNDED_SORTED_TOP_K_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define BSK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define BSK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define BSK_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bsk_pkg.sv */
// ----------------------------------------------------------------------------
// bsk_pkg
// Types, constants and helpers of the bounded sorted top-k list.
// ----------------------------------------------------------------------------
package bsk_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = 4;   // index into the entry store
  localparam int CNT_W    = 5;   // count, 0 .. CAPACITY
  localparam int SCORE_W  = 31;
  localparam int LEVEL_W  = 16;
  localparam int TAG_W    = 16;
  localparam int ENTRY_W  = SCORE_W + LEVEL_W + TAG_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LEVEL_W-1:0] level;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [SCORE_W-1:0] new_score;
    logic [LEVEL_W-1:0] new_level;
    logic [TAG_W-1:0]   new_tag;
    logic [7:0]         read_index;
  } cmd_word_t;

  typedef struct packed {
    logic               inserted;
    logic [IDX_W-1:0]   insert_position;
    logic               read_valid;
    logic [SCORE_W-1:0] read_score;
    logic [LEVEL_W-1:0] read_level;
    logic [TAG_W-1:0]   read_tag;
    logic [CNT_W-1:0]   entry_count;
  } rsp_word_t;

  // Saturate the configured limit at the capacity.
  function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] cap;
    cap = CNT_W'(CAPACITY);
    return (lim > cap) ? cap : lim;
  endfunction

  // New entry beats a stored one: higher score, or equal score and higher level.
  function automatic logic beats(input logic [SCORE_W-1:0] s,
                                 input logic [LEVEL_W-1:0] l,
                                 input entry_t e);
    return (s > e.score) || ((s == e.score) && (l > e.level));
  endfunction

endpackage

/* rtl/bsk_cmd_if.sv */
// ----------------------------------------------------------------------------
// bsk_cmd_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface bsk_cmd_if;
  logic                valid;
  logic                ready;
  bsk_pkg::cmd_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bsk_rsp_if.sv */
// ----------------------------------------------------------------------------
// bsk_rsp_if
// Response channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface bsk_rsp_if;
  logic                valid;
  logic                ready;
  bsk_pkg::rsp_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bsk_ram.sv */
// ----------------------------------------------------------------------------
// bsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bounded_sorted_top_k_insert_unit.sv */
// Sequence: insert scans for the first entry it beats, moves the tail down a slot
//   on a win, then stores the entry and publishes; a rejected insert only publishes.
//   Read fetches the addressed slot, then publishes; clear/unused op publishes directly.
// Throughput: one command at a time; the next is taken the cycle after the publish.
// Reset (rst, synchronous): list empty, limit 16, no response pending; the entry
//   store is not cleared, only positions below the count are ever reported.
// ----------------------------------------------------------------------------
// bounded_sorted_top_k_insert_unit
// Sorted top-k list of (score, level, tag) entries with insert, read and clear.
// A small sequencer walks the entry RAM with one comparator, then shifts the
// tail down one slot per cycle through the same RAM port pair.
// ----------------------------------------------------------------------------
module bounded_sorted_top_k_insert_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsk_pkg::CNT_W-1:0] cfg_wdata,
  bsk_cmd_if.sink                   cmd,
  bsk_rsp_if.source                 rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RDTAKE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Control state
  logic [2:0]                state;
  logic [bsk_pkg::CNT_W-1:0] count;
  logic [bsk_pkg::CNT_W-1:0] limit;
  logic [bsk_pkg::CNT_W-1:0] ptr;       // next address to issue during the scan
  logic                      rd_ok;     // read data of cmp_idx is on rdata
  logic                      iss;       // shift: still issuing reads
  logic                      pend;      // shift: a write of rdata is due
  logic                      res_ins;
  logic                      res_rv;
  logic                      rsp_valid_q;
  logic                      rsp_load;  // response register takes a new word

  // Payload
  bsk_pkg::cmd_word_t        cmd_q;
  logic [bsk_pkg::IDX_W-1:0] cmp_idx;
  logic [bsk_pkg::IDX_W-1:0] pos;
  logic [bsk_pkg::IDX_W-1:0] sptr;
  logic [bsk_pkg::IDX_W-1:0] sh_dst;
  bsk_pkg::entry_t           res_entry;
  bsk_pkg::rsp_word_t        rsp_q;

  // RAM port
  logic                      ram_we;
  logic [bsk_pkg::IDX_W-1:0] ram_waddr;
  bsk_pkg::entry_t           ram_wdata;
  logic [bsk_pkg::IDX_W-1:0] ram_raddr;
  bsk_pkg::entry_t           ram_rdata;

  // Scan decisions
  logic [bsk_pkg::CNT_W-1:0] lim_eff;
  logic [bsk_pkg::CNT_W-1:0] lim_m1;
  logic                      room;
  logic                      beat;
  logic                      scan_end;
  logic [bsk_pkg::IDX_W-1:0] last;
  logic [bsk_pkg::CNT_W-1:0] cfg_eff;
  bsk_pkg::entry_t           new_entry;

  assign lim_eff  = bsk_pkg::eff_limit(limit);
  assign lim_m1   = lim_eff - bsk_pkg::CNT_W'(1);
  assign room     = (count < lim_eff);
  assign beat     = rd_ok && bsk_pkg::beats(cmd_q.new_score, cmd_q.new_level, ram_rdata);
  // Every stored entry compared, or the list is empty.
  assign scan_end = (count == '0) ||
                    (rd_ok && (({1'b0, cmp_idx} + bsk_pkg::CNT_W'(1)) == count));
  // Last slot that receives a shifted entry: the tail grows while there is room,
  // else the final entry falls off.
  assign last     = room ? count[bsk_pkg::IDX_W-1:0] : lim_m1[bsk_pkg::IDX_W-1:0];
  assign cfg_eff  = bsk_pkg::eff_limit(cfg_wdata);

  assign new_entry.score = cmd_q.new_score;
  assign new_entry.level = cmd_q.new_level;
  assign new_entry.tag   = cmd_q.new_tag;

  // Steer the single read port and the single write port by state.
  always_comb begin
    case (state)
      S_SCAN:   ram_raddr = ptr[bsk_pkg::IDX_W-1:0];
      S_SHIFT:  ram_raddr = sptr;
      S_RDWAIT: ram_raddr = cmd_q.read_index[bsk_pkg::IDX_W-1:0];
      default:  ram_raddr = '0;
    endcase
  end

  assign ram_we    = ((state == S_SHIFT) && pend) || (state == S_PUT);
  assign ram_waddr = (state == S_PUT) ? pos : sh_dst;
  assign ram_wdata = (state == S_PUT) ? new_entry : ram_rdata;

  bsk_ram #(
    .WIDTH (bsk_pkg::ENTRY_W),
    .DEPTH (bsk_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accept commands only between operations; the response register frees the
  // sequencer from the sink's pace except when a second response would collide.
  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // Publish when the response register is free or being emptied.
  assign rsp_load  = (state == S_DONE) && (!rsp_valid_q || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      limit       <= bsk_pkg::CNT_W'(16);
      ptr         <= '0;
      rd_ok       <= 1'b0;
      iss         <= 1'b0;
      pend        <= 1'b0;
      res_ins     <= 1'b0;
      res_rv      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      // Load a new word, or drop the current one once the sink takes it.
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q     <= cmd.data;
            res_ins   <= 1'b0;
            res_rv    <= 1'b0;
            res_entry <= '0;
            ptr       <= '0;
            rd_ok     <= 1'b0;
            case (cmd.data.op)
              bsk_pkg::OP_INSERT: state <= S_SCAN;
              bsk_pkg::OP_READ:   state <= S_RDWAIT;
              bsk_pkg::OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_SCAN: begin
          // Issue the next read while comparing the previous one.
          if (ptr < count) begin
            ptr     <= ptr + bsk_pkg::CNT_W'(1);
            rd_ok   <= 1'b1;
            cmp_idx <= ptr[bsk_pkg::IDX_W-1:0];
          end else begin
            rd_ok <= 1'b0;
          end

          if (beat) begin
            pos <= cmp_idx;
            if (room) begin
              count <= count + bsk_pkg::CNT_W'(1);
            end
            if (last > cmp_idx) begin
              sptr  <= last - bsk_pkg::IDX_W'(1);
              iss   <= 1'b1;
              pend  <= 1'b0;
              state <= S_SHIFT;
            end else begin
              state <= S_PUT;
            end
          end else if (scan_end) begin
            if (room) begin
              pos   <= count[bsk_pkg::IDX_W-1:0];
              count <= count + bsk_pkg::CNT_W'(1);
              state <= S_PUT;
            end else begin
              // List full and the entry beats none: reject.
              state <= S_DONE;
            end
          end
        end

        S_SHIFT: begin
          // Read slot sptr, write it to sptr+1 in the next cycle; walk toward pos.
          if (iss) begin
            sh_dst <= sptr + bsk_pkg::IDX_W'(1);
            pend   <= 1'b1;
            if (sptr == pos) begin
              iss <= 1'b0;
            end else begin
              sptr <= sptr - bsk_pkg::IDX_W'(1);
            end
          end else begin
            pend <= 1'b0;
            if (pend) begin
              state <= S_PUT;
            end
          end
        end

        S_PUT: begin
          res_ins <= 1'b1;
          state   <= S_DONE;
        end

        S_RDWAIT: begin
          state <= S_RDTAKE;
        end

        S_RDTAKE: begin
          if ({3'b000, count} > cmd_q.read_index) begin
            res_rv    <= 1'b1;
            res_entry <= ram_rdata;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // Hold until the response register is free or being emptied.
          if (rsp_load) begin
            rsp_q.inserted        <= res_ins;
            rsp_q.insert_position <= res_ins ? pos : '0;
            rsp_q.read_valid      <= res_rv;
            rsp_q.read_score      <= res_entry.score;
            rsp_q.read_level      <= res_entry.level;
            rsp_q.read_tag        <= res_entry.tag;
            rsp_q.entry_count     <= count;
            state                 <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Limit write: cut the list to the new limit, dropping the tail.
      if (cfg_we) begin
        limit <= cfg_wdata;
        if (count > cfg_eff) begin
          count <= cfg_eff;
        end
      end
    end
  end

endmodule

/* rtl/bsk_checker.sv */
// ----------------------------------------------------------------------------
// bsk_checker
// Port-level checks on the top-k list unit, attached by bind.
// ----------------------------------------------------------------------------
`include "bounded_sorted_top_k_insert_unit_macros.svh"

module bsk_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input bsk_pkg::rsp_word_t rsp_data
);

  // A stalled response word holds.
  `BSK_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
  // Reset leaves no response pending.
  `BSK_ASSERT_RST(a_rst_empty, rst, !rsp_valid)
  // The unit is busy right after taking a command.
  `BSK_ASSERT_NXT(a_busy, cmd_valid && cmd_ready, !cmd_ready)
  // An inserted entry lands inside the list.
  `BSK_ASSERT_IMP(a_pos_in_list, rsp_valid && rsp_data.inserted,
                  {1'b0, rsp_data.insert_position} < rsp_data.entry_count)
  // A word reports an insert or a read, never both.
  `BSK_ASSERT_IMP(a_one_kind, rsp_valid, !(rsp_data.inserted && rsp_data.read_valid))

endmodule

bind bounded_sorted_top_k_insert_unit bsk_checker u_bsk_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

/* sim/tb_bounded_sorted_top_k_insert_unit.sv */
// ----------------------------------------------------------------------------
// tb_bounded_sorted_top_k_insert_unit
// Self-checking bench for the sorted top-k list: a directed pass over ordering,
// ties, overflow, limit changes and the odd opcodes, then random traffic under
// several idle and stall mixes, each word checked against a local list model.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_top_k_insert_unit;

  // Opcode 3 has no name in the package; it must leave the list untouched.
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int HANG_LIMIT    = 4000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;   // long response hold-off for the pressure test
  localparam int MAX_SHOWN     = 10;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [bsk_pkg::CNT_W-1:0] cfg_wdata;

  bsk_cmd_if cmd_ch ();
  bsk_rsp_if rsp_ch ();

  bounded_sorted_top_k_insert_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // Local copy of the list: entries, how many are live, and the written limit.
  logic [bsk_pkg::SCORE_W-1:0] slot_score [bsk_pkg::CAPACITY];
  logic [bsk_pkg::LEVEL_W-1:0] slot_level [bsk_pkg::CAPACITY];
  logic [bsk_pkg::TAG_W-1:0]   slot_tag   [bsk_pkg::CAPACITY];
  int                          slot_count;
  int                          limit_setting;

  // Response words still owed by the block, oldest first.
  bsk_pkg::rsp_word_t          pending_rsp [$];

  int mismatch_count;
  int idle_pct;       // chance in 100 that the sender idles before a word
  int stall_pct;      // chance in 100 that the receiver drops ready in a cycle
  int hold_request;   // asks the receiver for a long hold-off of this many cycles
  int quiet_cycles;

  // Free-running clock, period 10.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit as the list sees it: the register saturates at the capacity.
  function automatic int effective_limit();
    return (limit_setting > bsk_pkg::CAPACITY) ? bsk_pkg::CAPACITY : limit_setting;
  endfunction

  // Advance the local list by one command and return the response it owes.
  function automatic bsk_pkg::rsp_word_t apply_list_op(input bsk_pkg::cmd_word_t w);
    bsk_pkg::rsp_word_t r;
    int                 pos;
    int                 lim;
    int                 last;
    int                 j;
    r   = '0;
    lim = effective_limit();
    case (w.op)
      bsk_pkg::OP_INSERT: begin
        // Walk to the first entry the new one beats: higher score, or a tie on
        // score broken by a higher level. Equal on both does not beat.
        pos = 0;
        while (pos < slot_count &&
               !(w.new_score > slot_score[pos] ||
                 (w.new_score == slot_score[pos] && w.new_level > slot_level[pos])))
          pos++;
        if (pos < slot_count) begin
          // Shift the tail down; on a full list the last entry falls off.
          last = (slot_count < lim) ? slot_count : lim - 1;
          for (j = last; j > pos; j--) begin
            slot_score[j] = slot_score[j-1];
            slot_level[j] = slot_level[j-1];
            slot_tag[j]   = slot_tag[j-1];
          end
          if (slot_count < lim) slot_count++;
        end else if (slot_count < lim) begin
          slot_count++;            // append at the end
        end else begin
          pos = -1;                // beats nothing and no room: rejected
        end
        if (pos >= 0) begin
          slot_score[pos]   = w.new_score;
          slot_level[pos]   = w.new_level;
          slot_tag[pos]     = w.new_tag;
          r.inserted        = 1'b1;
          r.insert_position = bsk_pkg::IDX_W'(pos);
        end
      end
      bsk_pkg::OP_READ: begin
        // Only live positions are readable; everything else reads as zero.
        if (int'(w.read_index) < slot_count) begin
          r.read_valid = 1'b1;
          r.read_score = slot_score[w.read_index[bsk_pkg::IDX_W-1:0]];
          r.read_level = slot_level[w.read_index[bsk_pkg::IDX_W-1:0]];
          r.read_tag   = slot_tag[w.read_index[bsk_pkg::IDX_W-1:0]];
        end
      end
      bsk_pkg::OP_CLEAR: slot_count = 0;
      default: ;
    endcase
    r.entry_count = bsk_pkg::CNT_W'(slot_count);
    return r;
  endfunction

  function automatic bsk_pkg::cmd_word_t make_word(
      input logic [1:0]                  op,
      input logic [bsk_pkg::SCORE_W-1:0] s,
      input logic [bsk_pkg::LEVEL_W-1:0] l,
      input logic [bsk_pkg::TAG_W-1:0]   t,
      input logic [7:0]                  idx);
    bsk_pkg::cmd_word_t w;
    w.op         = op;
    w.new_score  = s;
    w.new_level  = l;
    w.new_tag    = t;
    w.read_index = idx;
    return w;
  endfunction

  // Mostly inserts, scores drawn from a tiny pool so ties and equal entries
  // show up often; extremes and full-range values fill out the rest.
  function automatic bsk_pkg::cmd_word_t random_word();
    bsk_pkg::cmd_word_t w;
    int                 pick;
    pick = $urandom_range(99);
    w.op = (pick < 65) ? bsk_pkg::OP_INSERT :
           (pick < 95) ? bsk_pkg::OP_READ :
           (pick < 97) ? bsk_pkg::OP_CLEAR : OP_NOP;
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.new_score = bsk_pkg::SCORE_W'($urandom_range(7));
      w.new_level = bsk_pkg::LEVEL_W'($urandom_range(3));
    end else if (pick < 55) begin
      w.new_score = $urandom_range(1) ? {bsk_pkg::SCORE_W{1'b1}} : '0;
      w.new_level = $urandom_range(1) ? {bsk_pkg::LEVEL_W{1'b1}} : '0;
    end else begin
      w.new_score = bsk_pkg::SCORE_W'($urandom);
      w.new_level = bsk_pkg::LEVEL_W'($urandom);
    end
    w.new_tag    = bsk_pkg::TAG_W'($urandom);
    w.read_index = ($urandom_range(99) < 75) ? 8'($urandom_range(bsk_pkg::CAPACITY + 1))
                                             : 8'($urandom);
    return w;
  endfunction

  // Offer one command word, hold it until the block takes it, then log the
  // response it owes. Valid is left high so back-to-back words stay gapless.
  task automatic send_word(input bsk_pkg::cmd_word_t w);
    bsk_pkg::rsp_word_t owed;
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    owed = apply_list_op(w);
    pending_rsp = {pending_rsp, owed};
  endtask

  // Drop valid and hold until every owed response has come back.
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the limit register with the block idle; a lower limit trims the list.
  task automatic write_limit(input int value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= bsk_pkg::CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_setting = value;
    if (slot_count > effective_limit()) slot_count = effective_limit();
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
        $display("%s: expected %0h, got %0h", label, want, got);
    end
  endtask

  // Receiver: random stalls at stall_pct, or a long hold-off on request that
  // it counts down itself while the sender keeps pushing.
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every accepted response word against the oldest owed one.
  always @(posedge clk) begin
    bsk_pkg::rsp_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("response word with none owed: %h", rsp_ch.data);
      end else begin
        want = pending_rsp.pop_front();
        compare_field("inserted", 32'(want.inserted), 32'(rsp_ch.data.inserted));
        compare_field("insert_position", 32'(want.insert_position),
                      32'(rsp_ch.data.insert_position));
        compare_field("read_valid", 32'(want.read_valid), 32'(rsp_ch.data.read_valid));
        compare_field("read_score", 32'(want.read_score), 32'(rsp_ch.data.read_score));
        compare_field("read_level", 32'(want.read_level), 32'(rsp_ch.data.read_level));
        compare_field("read_tag", 32'(want.read_tag), 32'(rsp_ch.data.read_tag));
        compare_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.data.entry_count));
      end
    end
  end

  // Hang guard: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("bounded_sorted_top_k_insert_unit: mismatch");
        $finish;
      end
    end
  end

  // Ordering on an empty list and at the reset limit: extremes, appends, ties
  // on score broken by level, exact duplicates landing after the original,
  // reads in and out of range, the unused opcode, and clear.
  task automatic test_ordering_and_ties();
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd0));
    send_word(make_word(bsk_pkg::OP_READ,   '1, '1, '1, 8'hFF));
    send_word(make_word(bsk_pkg::OP_INSERT, {bsk_pkg::SCORE_W{1'b1}},
                        {bsk_pkg::LEVEL_W{1'b1}}, {bsk_pkg::TAG_W{1'b1}}, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, '0, '0, '0, '1));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd100, 16'd5, 16'h0001, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd100, 16'd5, 16'h0002, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd100, 16'd6, 16'h0003, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd100, 16'd4, 16'h0004, '0));
    for (int k = 0; k <= 6; k++)
      send_word(make_word(bsk_pkg::OP_READ, '0, '0, '0, 8'(k)));
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'hFF));
    send_word(make_word(OP_NOP,             '1, '1, '1, '1));
    send_word(make_word(bsk_pkg::OP_CLEAR,  '1, '1, '1, '1));
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd0));
  endtask

  // Small limit: fill it, reject a loser, push the last entry out with a
  // winner, then lower the limit under the count so the tail is cut.
  task automatic test_overflow_and_cut();
    write_limit(4);
    for (int k = 0; k < 4; k++)
      send_word(make_word(bsk_pkg::OP_INSERT, 31'(1000 - 10 * k), 16'd0, 16'(k), '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd5,    16'd0, 16'h00AA, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd2000, 16'd0, 16'h00BB, '0));
    send_word(make_word(bsk_pkg::OP_INSERT, 31'd995,  16'd9, 16'h00CC, '0));
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd3));
    write_limit(2);
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd1));
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd2));
  endtask

  // Limit of zero: every insert bounces and the list stays empty.
  task automatic test_zero_limit();
    write_limit(0);
    send_word(make_word(bsk_pkg::OP_INSERT, {bsk_pkg::SCORE_W{1'b1}},
                        {bsk_pkg::LEVEL_W{1'b1}}, 16'h1234, '0));
    send_word(make_word(bsk_pkg::OP_READ,   '0, '0, '0, 8'd0));
  endtask

  // Long receiver hold-off while commands keep coming, so the block backs up
  // and stalls its input; then a pause until everything owed has arrived.
  task automatic test_backpressure();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = LONG_HOLD;
    repeat (8) send_word(random_word());
    wait_for_drain();
    repeat (4) send_word(random_word());
  endtask

  task automatic test_random_traffic(input int count, input int sender_idle,
                                     input int receiver_stall, input int lim);
    write_limit(lim);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_word(random_word());
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    slot_count    = 0;
    limit_setting = bsk_pkg::CAPACITY;
    mismatch_count = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_request  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_ordering_and_ties();
    test_overflow_and_cut();
    test_zero_limit();
    test_backpressure();
    test_random_traffic(90, 0,  0,  16);
    test_random_traffic(80, 56, 0,  8);
    test_random_traffic(80, 0,  56, 31);
    test_random_traffic(80, 15, 15, 16);
    test_random_traffic(30, 15, 15, 1);

    // Let the last responses land, then give the block time to go quiet.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += pending_rsp.size();
    if (mismatch_count == 0)
      $display("bounded_sorted_top_k_insert_unit: match");
    else
      $display("bounded_sorted_top_k_insert_unit: mismatch");
    $finish;
  end

endmodule
